// ===== src/lwma_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lwma_pkg;

   // Leaf bound and derived widths
   localparam int MAX_LEAF_SAMPLES = 4096;
   localparam int CNT_W            = $clog2(MAX_LEAF_SAMPLES + 1);
   localparam int LOG_MAX          = $clog2(MAX_LEAF_SAMPLES);

   // Field widths
   localparam int DATA_W   = 16;   // Q8.8 input sample fields
   localparam int FLOOR_W  = 27;   // weight_floor register
   localparam int MW_W     = 16;   // mean weight, Q8.8
   localparam int MEAN_W   = 32;   // first moments, Q16.16
   localparam int XMEAN_W  = 48;   // cross moments, Q24.24

   // Datapath widths
   localparam int FAC_W    = 2 * DATA_W;           // w*x products
   localparam int PROD_W   = FAC_W + DATA_W;       // shared multiplier output
   localparam int WSUM_W   = DATA_W + LOG_MAX;     // weight sum
   localparam int MOM_W    = FAC_W + LOG_MAX;      // first moment sums
   localparam int CROSS_W  = PROD_W + LOG_MAX;     // cross moment sums
   localparam int DIV_W    = CROSS_W;              // divider dividend width
   localparam int ITER_W   = $clog2(DIV_W);
   localparam int CMP_W    = (WSUM_W > FLOOR_W) ? WSUM_W : FLOOR_W;

   // Multiply sequence: six products, one extra step to drain the last one
   localparam int MUL_STEPS = 6;
   localparam int STEP_W    = 3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_END,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_PUSH
   } state_type;

   // Quantity under division
   typedef enum logic [2:0] {
      Q_WEIGHT,
      Q_OUTCOME,
      Q_TREATMENT,
      Q_INSTRUMENT,
      Q_OUT_INST,
      Q_TRT_INST,
      Q_INST_SQ
   } qsel_type;

endpackage

`default_nettype wire

// ===== src/lwma_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Signed by unsigned restoring divider, one quotient bit per cycle,
// quotient truncated toward zero.
module lwma_div (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic signed [lwma_pkg::DIV_W-1:0]  dividend,
   input  wire logic        [lwma_pkg::CNT_W-1:0]  divisor,
   output logic                                    done,
   output logic signed      [lwma_pkg::DIV_W-1:0]  quotient
);
   import lwma_pkg::*;

   logic                    busy_ff;
   logic                    done_ff;
   logic [ITER_W-1:0]       iter_ff;
   logic                    neg_ff;
   logic [DIV_W-1:0]        shift_ff;
   logic [CNT_W-1:0]        rem_ff;
   logic [CNT_W-1:0]        div_ff;
   logic signed [DIV_W-1:0] quot_ff;

   logic [DIV_W-1:0]        mag;
   logic [CNT_W:0]          trial;
   logic                    ge;
   logic [CNT_W:0]          diff;
   logic [CNT_W-1:0]        rem_in;
   logic [DIV_W-1:0]        shift_in;

   always_comb begin
      mag      = dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
      trial    = {rem_ff, shift_ff[DIV_W-1]};
      ge       = trial >= {1'b0, div_ff};
      diff     = trial - {1'b0, div_ff};
      rem_in   = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      shift_in = {shift_ff[DIV_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else if (busy_ff) begin
         iter_ff <= iter_ff + ITER_W'(1);
         if (iter_ff == ITER_W'(DIV_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff   <= dividend[DIV_W-1];
         shift_ff <= mag;
         rem_ff   <= '0;
         div_ff   <= divisor;
      end else if (busy_ff) begin
         shift_ff <= shift_in;
         rem_ff   <= rem_in;
         if (iter_ff == ITER_W'(DIV_W - 1)) begin
            quot_ff <= neg_ff ? -signed'(shift_in) : signed'(shift_in);
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

// ===== src/leaf_weighted_moment_accumulator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// A sample that does not end its leaf is accepted, then takes 7 steps of the
//   one shared 32x16 multiplier, with req_stall high until they finish; a marker or dropped
//   sample that does not end its leaf leaves the unit ready for the next request.
// A last sample of a valid leaf reaches rsp after 7 mult steps, then 7 divisions
//   on the shared divider. An invalid leaf skips the divider.
// Reset (synchronous, active high) clears the sums, count, floor and rsp valid.
module leaf_weighted_moment_accumulator_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request channel
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [lwma_pkg::DATA_W-1:0]    req_sample_weight,
   input  wire logic signed [lwma_pkg::DATA_W-1:0]    req_outcome,
   input  wire logic signed [lwma_pkg::DATA_W-1:0]    req_treatment,
   input  wire logic signed [lwma_pkg::DATA_W-1:0]    req_instrument,
   input  wire logic                                  req_last,
   input  wire logic                                  req_no_sample,
   // response channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_leaf_valid,
   output logic signed [lwma_pkg::MW_W-1:0]           rsp_mean_weight,
   output logic signed [lwma_pkg::MEAN_W-1:0]         rsp_mean_outcome,
   output logic signed [lwma_pkg::MEAN_W-1:0]         rsp_mean_treatment,
   output logic signed [lwma_pkg::MEAN_W-1:0]         rsp_mean_instrument,
   output logic signed [lwma_pkg::XMEAN_W-1:0]        rsp_mean_outcome_instrument,
   output logic signed [lwma_pkg::XMEAN_W-1:0]        rsp_mean_treatment_instrument,
   output logic signed [lwma_pkg::XMEAN_W-1:0]        rsp_mean_instrument_squared,
   output logic                                       rsp_count_overflow,
   // configuration
   input  wire logic                                  csr_wr_en,
   input  wire logic        [lwma_pkg::FLOOR_W-1:0]   csr_wr_data
);
   import lwma_pkg::*;

   // ---------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------
   state_type state_ff, state_in;
   qsel_type  qsel_ff;

   logic [FLOOR_W-1:0]        floor_ff;

   // latched request transaction
   logic signed [DATA_W-1:0]  w_ff, y_ff, t_ff, z_ff;
   logic                      last_ff;

   logic [STEP_W-1:0]         step_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [FAC_W-1:0]   fac_ff [3];   // w*y, w*t, w*z for the cross terms

   logic signed [WSUM_W-1:0]  acc_w_ff;
   logic signed [MOM_W-1:0]   acc_m_ff [3];
   logic signed [CROSS_W-1:0] acc_x_ff [3];
   logic [CNT_W-1:0]          cnt_ff;
   logic                      ovf_ff;
   logic                      leafok_ff;

   logic                      rsp_valid_ff;

   // ---------------------------------------------------------------------
   // Handshake and control
   // ---------------------------------------------------------------------
   logic req_accept;
   logic take;        // accepted transaction carries a sample we keep
   logic cnt_full;
   logic rsp_taken;
   logic push_load;   // result moves into the response register
   logic div_start;
   logic div_done;
   logic signed [DIV_W-1:0] div_quot;
   logic signed [DIV_W-1:0] div_dividend;
   logic leaf_ok;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign cnt_full   = (cnt_ff == CNT_W'(MAX_LEAF_SAMPLES));
   assign take       = !req_no_sample && !cnt_full;
   assign rsp_taken  = rsp_valid_ff && !rsp_stall;
   assign push_load  = (state_ff == ST_PUSH) && (!rsp_valid_ff || !rsp_stall);

   // Leaf is valid when it has samples and |weight sum| exceeds the floor
   logic [WSUM_W-1:0] abs_w;
   always_comb begin
      abs_w   = acc_w_ff[WSUM_W-1] ? WSUM_W'(-acc_w_ff) : WSUM_W'(acc_w_ff);
      leaf_ok = (cnt_ff != '0) && (CMP_W'(abs_w) > CMP_W'(floor_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (take) begin
                  state_in = ST_MUL;
               end else if (req_last) begin
                  state_in = ST_END;
               end
            end
         end
         ST_MUL: begin
            if (step_ff == STEP_W'(MUL_STEPS)) begin
               state_in = last_ff ? ST_END : ST_IDLE;
            end
         end
         ST_END: begin
            state_in = leaf_ok ? ST_DIV_START : ST_PUSH;
         end
         ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = (qsel_ff == Q_INST_SQ) ? ST_PUSH : ST_DIV_START;
            end
         end
         ST_PUSH: begin
            if (push_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Configuration
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= '0;
      end else if (csr_wr_en) begin
         floor_ff <= csr_wr_data;
      end
   end

   // ---------------------------------------------------------------------
   // Request latch and step counter
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_accept) begin
         w_ff    <= req_sample_weight;
         y_ff    <= req_outcome;
         t_ff    <= req_treatment;
         z_ff    <= req_instrument;
         last_ff <= req_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (req_accept) begin
         step_ff <= '0;
      end else if (state_ff == ST_MUL) begin
         step_ff <= step_ff + STEP_W'(1);
      end
   end

   // ---------------------------------------------------------------------
   // Shared multiplier: step 0..2 form w*x, step 3..5 form (w*x)*z.
   // Product is registered and accumulated one step later.
   // ---------------------------------------------------------------------
   logic signed [FAC_W-1:0]  mul_a;
   logic signed [DATA_W-1:0] mul_b;
   logic signed [FAC_W-1:0]  w_ext;
   logic signed [PROD_W-1:0] mul_out;

   assign w_ext = signed'({{(FAC_W - DATA_W){w_ff[DATA_W-1]}}, w_ff});

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (step_ff)
         STEP_W'(0): begin mul_a = w_ext;     mul_b = y_ff; end
         STEP_W'(1): begin mul_a = w_ext;     mul_b = t_ff; end
         STEP_W'(2): begin mul_a = w_ext;     mul_b = z_ff; end
         STEP_W'(3): begin mul_a = fac_ff[0]; mul_b = z_ff; end
         STEP_W'(4): begin mul_a = fac_ff[1]; mul_b = z_ff; end
         STEP_W'(5): begin mul_a = fac_ff[2]; mul_b = z_ff; end
         default:    begin mul_a = '0;        mul_b = '0;   end
      endcase
      mul_out = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         prod_ff <= mul_out;
      end
   end

   // Shared accumulate adder
   logic signed [CROSS_W-1:0] add_a;
   logic signed [CROSS_W-1:0] add_sum;

   always_comb begin
      unique case (step_ff)
         STEP_W'(1): add_a = CROSS_W'(acc_m_ff[0]);
         STEP_W'(2): add_a = CROSS_W'(acc_m_ff[1]);
         STEP_W'(3): add_a = CROSS_W'(acc_m_ff[2]);
         STEP_W'(4): add_a = acc_x_ff[0];
         STEP_W'(5): add_a = acc_x_ff[1];
         STEP_W'(6): add_a = acc_x_ff[2];
         default:    add_a = '0;
      endcase
      add_sum = add_a + CROSS_W'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_MUL) && (step_ff >= STEP_W'(1)) && (step_ff <= STEP_W'(3))) begin
         fac_ff[step_ff[1:0] - 2'd1] <= prod_ff[FAC_W-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // Divider operand select
   // ---------------------------------------------------------------------
   always_comb begin
      unique case (qsel_ff)
         Q_WEIGHT:     div_dividend = DIV_W'(acc_w_ff);
         Q_OUTCOME:    div_dividend = DIV_W'(acc_m_ff[0]);
         Q_TREATMENT:  div_dividend = DIV_W'(acc_m_ff[1]);
         Q_INSTRUMENT: div_dividend = DIV_W'(acc_m_ff[2]);
         Q_OUT_INST:   div_dividend = acc_x_ff[0];
         Q_TRT_INST:   div_dividend = acc_x_ff[1];
         Q_INST_SQ:    div_dividend = acc_x_ff[2];
         default:      div_dividend = '0;
      endcase
   end

   lwma_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         qsel_ff <= Q_WEIGHT;
      end else if (state_ff == ST_END) begin
         qsel_ff <= Q_WEIGHT;
      end else if ((state_ff == ST_DIV_WAIT) && div_done && (qsel_ff != Q_INST_SQ)) begin
         qsel_ff <= qsel_type'(qsel_ff + 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_END) begin
         leafok_ff <= leaf_ok;
      end
   end

   // ---------------------------------------------------------------------
   // Accumulators: summed during the multiply steps, overwritten in place by
   // their quotients at leaf end, cleared when the result is pushed.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset || push_load) begin
         acc_w_ff <= '0;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            acc_m_ff[i] <= '0;
            acc_x_ff[i] <= '0;
         end
      end else begin
         // sample beyond the leaf bound is dropped and flagged
         if (req_accept && !req_no_sample && cnt_full) begin
            ovf_ff <= 1'b1;
         end
         if (state_ff == ST_MUL) begin
            if (step_ff == STEP_W'(0)) begin
               acc_w_ff <= acc_w_ff + WSUM_W'(w_ff);
               cnt_ff   <= cnt_ff + CNT_W'(1);
            end
            unique case (step_ff)
               STEP_W'(1): acc_m_ff[0] <= add_sum[MOM_W-1:0];
               STEP_W'(2): acc_m_ff[1] <= add_sum[MOM_W-1:0];
               STEP_W'(3): acc_m_ff[2] <= add_sum[MOM_W-1:0];
               STEP_W'(4): acc_x_ff[0] <= add_sum;
               STEP_W'(5): acc_x_ff[1] <= add_sum;
               STEP_W'(6): acc_x_ff[2] <= add_sum;
               default: ;
            endcase
         end
         if ((state_ff == ST_DIV_WAIT) && div_done) begin
            unique case (qsel_ff)
               Q_WEIGHT:     acc_w_ff    <= div_quot[WSUM_W-1:0];
               Q_OUTCOME:    acc_m_ff[0] <= div_quot[MOM_W-1:0];
               Q_TREATMENT:  acc_m_ff[1] <= div_quot[MOM_W-1:0];
               Q_INSTRUMENT: acc_m_ff[2] <= div_quot[MOM_W-1:0];
               Q_OUT_INST:   acc_x_ff[0] <= div_quot;
               Q_TRT_INST:   acc_x_ff[1] <= div_quot;
               Q_INST_SQ:    acc_x_ff[2] <= div_quot;
               default: ;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response register: holds a finished transaction while rsp is stalled
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_taken) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push_load) begin
         rsp_leaf_valid     <= leafok_ff;
         rsp_count_overflow <= ovf_ff;
         if (leafok_ff) begin
            rsp_mean_weight               <= acc_w_ff[MW_W-1:0];
            rsp_mean_outcome              <= acc_m_ff[0][MEAN_W-1:0];
            rsp_mean_treatment            <= acc_m_ff[1][MEAN_W-1:0];
            rsp_mean_instrument           <= acc_m_ff[2][MEAN_W-1:0];
            rsp_mean_outcome_instrument   <= acc_x_ff[0][XMEAN_W-1:0];
            rsp_mean_treatment_instrument <= acc_x_ff[1][XMEAN_W-1:0];
            rsp_mean_instrument_squared   <= acc_x_ff[2][XMEAN_W-1:0];
         end else begin
            // invalid leaf reports zero means
            rsp_mean_weight               <= '0;
            rsp_mean_outcome              <= '0;
            rsp_mean_treatment            <= '0;
            rsp_mean_instrument           <= '0;
            rsp_mean_outcome_instrument   <= '0;
            rsp_mean_treatment_instrument <= '0;
            rsp_mean_instrument_squared   <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_LEAF_SAMPLES))
      else $error("sample count above leaf bound");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> cnt_full)
      else $error("overflow flagged before count reached bound");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_WAIT))
      else $error("divider finished outside the wait state");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUSH && !rsp_valid_ff) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result push did not complete");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (step_ff <= STEP_W'(MUL_STEPS)))
      else $error("multiply step out of range");

endmodule

`default_nettype wire

// ===== bench/leaf_weighted_moment_accumulator_unit_tb.sv =====
`timescale 1ns / 1ps

module leaf_weighted_moment_accumulator_unit_tb;
   import lwma_pkg::*;

   // Each accepted request transaction is folded into a local copy of the leaf
   // sums; a transaction marked last closes the leaf and queues the expected
   // summary. Every accepted response transaction is checked field by field
   // against the oldest queued summary.

   localparam int CLK_PERIOD      = 10;
   localparam int RESET_CYCLES    = 10;
   localparam int SETTLE_CYCLES   = 16;     // longer than one multiply sequence
   localparam int END_CYCLES      = 500;    // longer than one full divide pass
   localparam int HOLD_OFF_CYCLES = 2500;
   localparam int QUIET_LIMIT     = 20000;  // cycles with no transaction at all
   localparam int MAX_PRINTED     = 100;
   localparam int PHASE_ITEMS     = 190;

   localparam logic [FLOOR_W-1:0] FLOOR_MAX = {FLOOR_W{1'b1}};

   typedef logic signed [DATA_W-1:0] q88_type;

   typedef struct {
      q88_type weight;
      q88_type outcome;
      q88_type treatment;
      q88_type instrument;
      logic    last;
      logic    no_sample;
   } sample_type;

   typedef struct {
      logic                      leaf_valid;
      logic signed [MW_W-1:0]    mean_weight;
      logic signed [MEAN_W-1:0]  mean_outcome;
      logic signed [MEAN_W-1:0]  mean_treatment;
      logic signed [MEAN_W-1:0]  mean_instrument;
      logic signed [XMEAN_W-1:0] mean_outcome_instrument;
      logic signed [XMEAN_W-1:0] mean_treatment_instrument;
      logic signed [XMEAN_W-1:0] mean_instrument_squared;
      logic                      count_overflow;
   } leaf_summary_type;

   // DUT connections; every DUT input is driven to a known value from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   q88_type req_sample_weight = '0;
   q88_type req_outcome = '0;
   q88_type req_treatment = '0;
   q88_type req_instrument = '0;
   logic req_last = 1'b0;
   logic req_no_sample = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_leaf_valid;
   logic signed [MW_W-1:0]    rsp_mean_weight;
   logic signed [MEAN_W-1:0]  rsp_mean_outcome;
   logic signed [MEAN_W-1:0]  rsp_mean_treatment;
   logic signed [MEAN_W-1:0]  rsp_mean_instrument;
   logic signed [XMEAN_W-1:0] rsp_mean_outcome_instrument;
   logic signed [XMEAN_W-1:0] rsp_mean_treatment_instrument;
   logic signed [XMEAN_W-1:0] rsp_mean_instrument_squared;
   logic rsp_count_overflow;
   logic csr_wr_en = 1'b0;
   logic [FLOOR_W-1:0] csr_wr_data = '0;

   // Local copy of the leaf state and the floor register
   longint             sum_w, sum_wy, sum_wt, sum_wz, sum_wyz, sum_wtz, sum_wzz;
   int                 model_count;
   bit                 leaf_overflow;
   logic [FLOOR_W-1:0] model_floor;

   leaf_summary_type expected_summaries[$];

   // Idle/stall control
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_off_left = 0;

   // Bookkeeping
   int mismatch_count = 0;
   int results_checked = 0;
   int valid_leaves = 0;
   int overflow_leaves = 0;
   int samples_sent = 0;
   int quiet_cycles = 0;

   leaf_weighted_moment_accumulator_unit dut (
      .clock                         (clock),
      .reset                         (reset),
      .req_valid                     (req_valid),
      .req_stall                     (req_stall),
      .req_sample_weight             (req_sample_weight),
      .req_outcome                   (req_outcome),
      .req_treatment                 (req_treatment),
      .req_instrument                (req_instrument),
      .req_last                      (req_last),
      .req_no_sample                 (req_no_sample),
      .rsp_valid                     (rsp_valid),
      .rsp_stall                     (rsp_stall),
      .rsp_leaf_valid                (rsp_leaf_valid),
      .rsp_mean_weight               (rsp_mean_weight),
      .rsp_mean_outcome              (rsp_mean_outcome),
      .rsp_mean_treatment            (rsp_mean_treatment),
      .rsp_mean_instrument           (rsp_mean_instrument),
      .rsp_mean_outcome_instrument   (rsp_mean_outcome_instrument),
      .rsp_mean_treatment_instrument (rsp_mean_treatment_instrument),
      .rsp_mean_instrument_squared   (rsp_mean_instrument_squared),
      .rsp_count_overflow            (rsp_count_overflow),
      .csr_wr_en                     (csr_wr_en),
      .csr_wr_data                   (csr_wr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------
   // Leaf moment prediction
   // ---------------------------------------------------------------------
   function automatic void clear_leaf_moments();
      sum_w = 0;
      sum_wy = 0;
      sum_wt = 0;
      sum_wz = 0;
      sum_wyz = 0;
      sum_wtz = 0;
      sum_wzz = 0;
      model_count = 0;
      leaf_overflow = 1'b0;
   endfunction

   // Fold one accepted transaction in; a last transaction queues the summary.
   function automatic void update_leaf_moments(input sample_type item);
      longint           w, z, wy, wt, wz, abs_w, n;
      leaf_summary_type summary;
      if (!item.no_sample) begin
         // count saturates at the bound; extra samples are dropped
         if (model_count >= MAX_LEAF_SAMPLES) begin
            leaf_overflow = 1'b1;
         end else begin
            w  = longint'(item.weight);
            z  = longint'(item.instrument);
            wy = w * longint'(item.outcome);
            wt = w * longint'(item.treatment);
            wz = w * z;
            sum_w   += w;
            sum_wy  += wy;
            sum_wt  += wt;
            sum_wz  += wz;
            sum_wyz += wy * z;
            sum_wtz += wt * z;
            sum_wzz += wz * z;
            model_count++;
         end
      end
      if (item.last) begin
         summary = '{default: '0};
         abs_w = (sum_w < 0) ? -sum_w : sum_w;
         // empty leaf or |weight sum| <= floor: all means stay zero
         if (model_count != 0 && abs_w > longint'(model_floor)) begin
            n = longint'(model_count);
            summary.leaf_valid                = 1'b1;
            summary.mean_weight               = MW_W'(sum_w / n);
            summary.mean_outcome              = MEAN_W'(sum_wy / n);
            summary.mean_treatment            = MEAN_W'(sum_wt / n);
            summary.mean_instrument           = MEAN_W'(sum_wz / n);
            summary.mean_outcome_instrument   = XMEAN_W'(sum_wyz / n);
            summary.mean_treatment_instrument = XMEAN_W'(sum_wtz / n);
            summary.mean_instrument_squared   = XMEAN_W'(sum_wzz / n);
         end
         summary.count_overflow = leaf_overflow;
         expected_summaries.push_back(summary);
         clear_leaf_moments();
      end
   endfunction

   // ---------------------------------------------------------------------
   // Transaction builders
   // ---------------------------------------------------------------------
   function automatic sample_type sample_of(input int w, input int y, input int t,
                                            input int z, input logic last);
      sample_type item;
      item.weight     = q88_type'(w);
      item.outcome    = q88_type'(y);
      item.treatment  = q88_type'(t);
      item.instrument = q88_type'(z);
      item.last       = last;
      item.no_sample  = 1'b0;
      return item;
   endfunction

   // Marker carries garbage data that must be ignored
   function automatic sample_type marker_of(input logic last);
      sample_type item;
      item = sample_of(int'($urandom()), int'($urandom()), int'($urandom()),
                       int'($urandom()), last);
      item.no_sample = 1'b1;
      return item;
   endfunction

   // Full-range Q8.8 with extra weight on the extremes, zero and small values
   function automatic int random_q88();
      case ($urandom_range(7))
         0: return -32768;
         1: return 32767;
         2: return 0;
         3: return int'($urandom_range(511)) - 256;
         default: return int'(q88_type'($urandom()));
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Request driver
   // ---------------------------------------------------------------------
   task automatic offer_sample(input sample_type item);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_sample_weight <= item.weight;
      req_outcome       <= item.outcome;
      req_treatment     <= item.treatment;
      req_instrument    <= item.instrument;
      req_last          <= item.last;
      req_no_sample     <= item.no_sample;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      update_leaf_moments(item);
      if (!item.no_sample) samples_sent++;
   endtask

   // Only called once the block is idle
   task automatic write_weight_floor(input int value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= FLOOR_W'(value);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      model_floor = FLOOR_W'(value);
   endtask

   // Drop valid, collect every pending summary, then let the datapath settle
   task automatic wait_for_summaries();
      req_valid <= 1'b0;
      while (expected_summaries.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Response checking
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) $display("%0t MISMATCH: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic signed [63:0] got,
                              input logic signed [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("summary %0d %s: got %0d, expected %0d",
                                   results_checked, name, got, want));
   endtask

   task automatic check_leaf_summary();
      leaf_summary_type want;
      if (expected_summaries.size() == 0) begin
         report_mismatch($sformatf("summary %0d arrived with no leaf pending",
                                   results_checked));
      end else begin
         want = expected_summaries.pop_front();
         check_field("leaf_valid", 64'(rsp_leaf_valid), 64'(want.leaf_valid));
         check_field("mean_weight", 64'(rsp_mean_weight), 64'(want.mean_weight));
         check_field("mean_outcome", 64'(rsp_mean_outcome), 64'(want.mean_outcome));
         check_field("mean_treatment", 64'(rsp_mean_treatment),
                     64'(want.mean_treatment));
         check_field("mean_instrument", 64'(rsp_mean_instrument),
                     64'(want.mean_instrument));
         check_field("mean_outcome_instrument", 64'(rsp_mean_outcome_instrument),
                     64'(want.mean_outcome_instrument));
         check_field("mean_treatment_instrument", 64'(rsp_mean_treatment_instrument),
                     64'(want.mean_treatment_instrument));
         check_field("mean_instrument_squared", 64'(rsp_mean_instrument_squared),
                     64'(want.mean_instrument_squared));
         check_field("count_overflow", 64'(rsp_count_overflow),
                     64'(want.count_overflow));
         if (want.leaf_valid) valid_leaves++;
         if (want.count_overflow) overflow_leaves++;
      end
      results_checked++;
   endtask

   // Receiver: samples at the edge, then picks the stall for the next cycle.
   // A pending hold-off wins over the random stall pattern.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_leaf_summary();
      if (hold_off_left > 0) begin
         rsp_stall <= 1'b1;
         hold_off_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // Watchdog: any stretch this long without a transaction means a hang
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t watchdog: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // One-sample leaves at the corners of the Q8.8 range
   task automatic test_extreme_single_samples();
      offer_sample(sample_of(32767, 32767, 32767, 32767, 1'b1));
      offer_sample(sample_of(-32768, -32768, -32768, -32768, 1'b1));
      offer_sample(sample_of(-32768, 32767, -32768, -32768, 1'b1));
      wait_for_summaries();
   endtask

   // Markers inside and at the end of a leaf, empty leaves, zero weight sum,
   // and sums that do not divide evenly (truncation toward zero)
   task automatic test_markers_and_truncation();
      offer_sample(sample_of(3, -7, 5, -11, 1'b0));
      offer_sample(marker_of(1'b0));
      offer_sample(sample_of(-1, 2, -9, 4, 1'b0));
      offer_sample(sample_of(2, 1, 1, -32768, 1'b1));
      // marker-only leaf
      offer_sample(marker_of(1'b1));
      // leaf closed by a marker
      offer_sample(sample_of(-300, 1234, -77, 501, 1'b0));
      offer_sample(sample_of(-5, -32000, 999, -3, 1'b0));
      offer_sample(marker_of(1'b1));
      // weight sum zero with floor zero: invalid
      offer_sample(sample_of(100, 200, 300, 400, 1'b0));
      offer_sample(sample_of(-100, 5, 6, 7, 1'b1));
      offer_sample(marker_of(1'b1));
      wait_for_summaries();
   endtask

   // |weight sum| equal to the floor is invalid, one above is valid
   task automatic test_weight_floor_boundary();
      write_weight_floor(256);
      offer_sample(sample_of(256, 111, 222, 333, 1'b1));
      offer_sample(sample_of(257, 111, 222, 333, 1'b1));
      offer_sample(sample_of(-256, -111, 222, -333, 1'b1));
      offer_sample(sample_of(-257, -111, 222, -333, 1'b1));
      wait_for_summaries();
      write_weight_floor(int'(FLOOR_MAX));
      offer_sample(sample_of(-32768, 32767, 32767, 32767, 1'b1));
      wait_for_summaries();
   endtask

   // One leaf that fills to the bound and then drops two extra samples
   task automatic test_count_saturation();
      int i;
      // 4096 samples of -128.0 give |sum| = 2^27, just above the largest floor;
      // the two dropped samples carry random data that must not show up
      for (i = 0; i < MAX_LEAF_SAMPLES + 2; i++) begin
         if (i < MAX_LEAF_SAMPLES)
            offer_sample(sample_of(-32768, -32768, -32768, -32768, 1'b0));
         else
            offer_sample(sample_of(random_q88(), random_q88(), random_q88(), random_q88(),
                                   i == MAX_LEAF_SAMPLES + 1));
      end
      wait_for_summaries();
      write_weight_floor(0);
      // overflow flag must not leak into the next leaf
      offer_sample(sample_of(random_q88(), random_q88(), random_q88(), random_q88(), 1'b0));
      offer_sample(sample_of(random_q88(), random_q88(), random_q88(), random_q88(), 1'b1));
      wait_for_summaries();
   endtask

   // Receiver holds off for a long stretch while short leaves keep coming,
   // so the result path fills and the request side has to stall
   task automatic test_result_backpressure();
      int i;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_off_left = HOLD_OFF_CYCLES;
      for (i = 0; i < 12; i++)
         offer_sample(sample_of(random_q88(), random_q88(), random_q88(), random_q88(), 1'b1));
      wait_for_summaries();
   endtask

   // One random leaf; returns the transactions that count toward the total
   task automatic send_random_leaf(output int counted);
      int      n_samples, i;
      bit      small_weights, end_on_marker;
      int      w;
      counted = 0;
      if ($urandom_range(14) == 0) begin
         offer_sample(marker_of(1'b1));
         counted = 1;
      end else begin
         n_samples     = ($urandom_range(7) == 0) ? $urandom_range(40, 9)
                                                  : $urandom_range(8, 1);
         small_weights = ($urandom_range(3) == 0);
         end_on_marker = ($urandom_range(7) == 0);
         for (i = 0; i < n_samples; i++) begin
            if ($urandom_range(9) == 0) offer_sample(marker_of(1'b0));
            w = small_weights ? int'($urandom_range(127)) - 64 : random_q88();
            offer_sample(sample_of(w, random_q88(), random_q88(), random_q88(),
                                   i == n_samples - 1 && !end_on_marker));
            counted++;
         end
         if (end_on_marker) begin
            offer_sample(marker_of(1'b1));
            counted++;
         end
      end
   endtask

   task automatic test_random_leaves(input int target, input int send_pct,
                                     input int recv_pct, input int floor_value);
      int sent, counted;
      write_weight_floor(floor_value);
      sender_idle_pct = send_pct;
      receiver_stall_pct = recv_pct;
      sent = 0;
      while (sent < target) begin
         send_random_leaf(counted);
         sent += counted;
      end
      wait_for_summaries();
   endtask

   initial begin
      clear_leaf_moments();
      model_floor = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_weight_floor(0);
      test_extreme_single_samples();
      test_markers_and_truncation();
      test_weight_floor_boundary();
      test_count_saturation();
      test_result_backpressure();
      test_random_leaves(PHASE_ITEMS, 0, 0, 0);
      test_random_leaves(PHASE_ITEMS, 68, 0, 40000);
      test_random_leaves(PHASE_ITEMS, 0, 68, 300);
      test_random_leaves(PHASE_ITEMS, 26, 26, 120000);

      // late or extra results would show up here
      repeat (END_CYCLES) @(posedge clock);

      $display("Checked %0d leaf summaries over %0d samples: %0d valid, %0d invalid,",
               results_checked, samples_sent, valid_leaves, results_checked - valid_leaves);
      $display("%0d overflowed; covered floor edges, markers, empty leaves, saturation, stalls.",
               overflow_leaves);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
